/* rtl/response_bin_update_assert.svh */
// assertion macros for the response bin update block
// used by response_bin_update.sv, no other dependencies
`ifndef RESPONSE_BIN_UPDATE_ASSERT_SVH
`define RESPONSE_BIN_UPDATE_ASSERT_SVH
`ifndef SYNTH
`define RBU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("response_bin_update: implication check failed");
`define RBU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("response_bin_update: next cycle check failed");
`else
`define RBU_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define RBU_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/rbu_pkg.sv */
// widths, constants and types of the response bin update block
// no dependencies
`timescale 1ns / 1ps
package rbu_pkg;
	localparam int DATA_W    = 32;
	localparam int FACT_W    = 18;
	localparam int CFG_IDX_W = 2;
	localparam int SCL_W     = 51;
	localparam int LO_W      = 25;
	localparam int HALF_W    = SCL_W - LO_W;
	localparam int PP_W      = 2 * HALF_W;
	localparam int PROD_W    = 102;
	localparam int SUM_W     = PROD_W + 1;
	localparam int MAG_W     = 102;
	localparam int DIV_W     = 134;
	localparam int QUO_W     = 34;
	localparam int FRAC_SH   = 17;
	localparam int NUM_PROD  = 6;
	localparam int FRONT_ST  = 6;
	localparam int NUM_ST    = FRONT_ST + QUO_W + 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ALPHA = 2'd0,
		CFG_GAMMA = 2'd1,
		CFG_MODE  = 2'd2
	} cfg_idx_t;

	localparam logic [FACT_W-1:0]       FACT_ONE = 18'h10000;
	localparam logic signed [SCL_W-1:0] ONE_Q32  = 51'sh1_0000_0000;
	localparam logic [QUO_W-1:0]        LIM_POS  = 34'h0_7FFF_FFFF;
	localparam logic [QUO_W-1:0]        LIM_NEG  = 34'h0_8000_0000;
	localparam logic [DATA_W-1:0]       RESP_MAX = 32'h7FFF_FFFF;
	localparam logic [DATA_W-1:0]       RESP_MIN = 32'h8000_0000;

	typedef struct packed {
		logic [DIV_W-1:0] den;
		logic [DIV_W-1:0] rem_r;
		logic [DIV_W-1:0] rem_i;
		logic [QUO_W-1:0] q_r;
		logic [QUO_W-1:0] q_i;
		logic             neg_r;
		logic             neg_i;
		logic             zero;
		logic             last;
	} div_t;
endpackage

/* rtl/response_bin_update.sv */
// response bin update: scaled complex quotient (G*gamma + 1) / (C*factor) per bin
// depends on rbu_pkg.sv and response_bin_update_assert.svh
// one bin accepted per cycle while bin_stall is low
// the pipeline has six front stages (scale, partial products, full products, sums,
// magnitude, dividend) plus one restoring division stage per quotient bit (34) and an output stage
// a stalled output freezes only the full stages behind it, bubbles still fill
// arst_n clears valid bits and sets alpha and gamma to 1.0 and the mode to 0
`timescale 1ns / 1ps
module response_bin_update (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                bin_valid,
	output logic                                bin_stall,
	input  logic signed [rbu_pkg::DATA_W-1:0]   cavity_real,
	input  logic signed [rbu_pkg::DATA_W-1:0]   cavity_imag,
	input  logic signed [rbu_pkg::DATA_W-1:0]   loop_real,
	input  logic signed [rbu_pkg::DATA_W-1:0]   loop_imag,
	input  logic                                last_bin,
	output logic                                resp_valid,
	input  logic                                resp_stall,
	output logic signed [rbu_pkg::DATA_W-1:0]   resp_real,
	output logic signed [rbu_pkg::DATA_W-1:0]   resp_imag,
	output logic                                zero_divisor,
	output logic                                saturated,
	output logic                                last_out,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [rbu_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [rbu_pkg::FACT_W-1:0]          cfg_data
);
	import rbu_pkg::*;

	`include "response_bin_update_assert.svh"

	logic [FACT_W-1:0] alpha_q, gamma_q;
	logic              mode_q;

	logic [NUM_ST-1:0] vld_s;
	logic [NUM_ST-1:0] en;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= FACT_ONE;
			gamma_q <= FACT_ONE;
			mode_q  <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_ALPHA: alpha_q <= cfg_data;
				CFG_GAMMA: gamma_q <= cfg_data;
				CFG_MODE:  mode_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// stage enables: a stage moves when the output drains or a bubble lies ahead
	always_comb begin
		for (int k = 0; k < NUM_ST; k++) begin
			en[k] = !resp_stall ||
				!(&(vld_s | ((NUM_ST'(1) << k) - NUM_ST'(1))));
		end
	end

	assign bin_stall  = !en[0];
	assign resp_valid = vld_s[NUM_ST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 0; k < NUM_ST; k++) begin
				if (en[k]) begin
					vld_s[k] <= (k == 0) ? bin_valid : vld_s[(k == 0) ? 0 : k - 1];
				end
			end
		end
	end

	// stage 1: scaling
	logic signed [SCL_W-1:0] cr_s1, ci_s1, nr_s1, ni_s1;
	logic                    last_s1;
	logic signed [FACT_W:0]  cf_sx, gam_sx;

	assign cf_sx  = $signed({1'b0, (mode_q ? alpha_q : gamma_q)});
	assign gam_sx = $signed({1'b0, gamma_q});

	always_ff @(posedge clk) begin
		if (en[0]) begin
			cr_s1   <= SCL_W'(cavity_real) * SCL_W'(cf_sx);
			ci_s1   <= SCL_W'(cavity_imag) * SCL_W'(cf_sx);
			nr_s1   <= SCL_W'(loop_real) * SCL_W'(gam_sx) + ONE_Q32;
			ni_s1   <= SCL_W'(loop_imag) * SCL_W'(gam_sx);
			last_s1 <= last_bin;
		end
	end

	// stage 2: partial products
	logic signed [SCL_W-1:0] opa [NUM_PROD];
	logic signed [SCL_W-1:0] opb [NUM_PROD];
	logic signed [PP_W-1:0]  hh_c [NUM_PROD];
	logic signed [PP_W-1:0]  hl_c [NUM_PROD];
	logic signed [PP_W-1:0]  lh_c [NUM_PROD];
	logic signed [PP_W-1:0]  ll_c [NUM_PROD];
	logic signed [PP_W-1:0]  hh_s2 [NUM_PROD];
	logic signed [PP_W-1:0]  hl_s2 [NUM_PROD];
	logic signed [PP_W-1:0]  lh_s2 [NUM_PROD];
	logic signed [PP_W-1:0]  ll_s2 [NUM_PROD];
	logic                    zero_s2, last_s2;

	// d = cr*cr + ci*ci, pr = nr*cr + ni*ci, pi = ni*cr - nr*ci
	assign opa[0] = cr_s1; assign opb[0] = cr_s1;
	assign opa[1] = ci_s1; assign opb[1] = ci_s1;
	assign opa[2] = nr_s1; assign opb[2] = cr_s1;
	assign opa[3] = ni_s1; assign opb[3] = ci_s1;
	assign opa[4] = ni_s1; assign opb[4] = cr_s1;
	assign opa[5] = nr_s1; assign opb[5] = ci_s1;

	always_comb begin
		for (int k = 0; k < NUM_PROD; k++) begin
			hh_c[k] = $signed(opa[k][SCL_W-1:LO_W]) * $signed(opb[k][SCL_W-1:LO_W]);
			hl_c[k] = $signed(opa[k][SCL_W-1:LO_W]) * $signed({1'b0, opb[k][LO_W-1:0]});
			lh_c[k] = $signed({1'b0, opa[k][LO_W-1:0]}) * $signed(opb[k][SCL_W-1:LO_W]);
			ll_c[k] = $signed({1'b0, opa[k][LO_W-1:0]}) * $signed({1'b0, opb[k][LO_W-1:0]});
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			hh_s2   <= hh_c;
			hl_s2   <= hl_c;
			lh_s2   <= lh_c;
			ll_s2   <= ll_c;
			zero_s2 <= (cr_s1 == '0) && (ci_s1 == '0);
			last_s2 <= last_s1;
		end
	end

	// stage 3: full products
	logic signed [PROD_W-1:0] prod_s3 [NUM_PROD];
	logic                     zero_s3, last_s3;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int k = 0; k < NUM_PROD; k++) begin
				prod_s3[k] <= (PROD_W'(hh_s2[k]) <<< (2 * LO_W)) +
					((PROD_W'(hl_s2[k]) + PROD_W'(lh_s2[k])) <<< LO_W) +
					PROD_W'(ll_s2[k]);
			end
			zero_s3 <= zero_s2;
			last_s3 <= last_s2;
		end
	end

	// stage 4: divisor and numerators
	logic signed [SUM_W-1:0] d_s4, pr_s4, pi_s4;
	logic                    zero_s4, last_s4;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			d_s4    <= SUM_W'(prod_s3[0]) + SUM_W'(prod_s3[1]);
			pr_s4   <= SUM_W'(prod_s3[2]) + SUM_W'(prod_s3[3]);
			pi_s4   <= SUM_W'(prod_s3[4]) - SUM_W'(prod_s3[5]);
			zero_s4 <= zero_s3;
			last_s4 <= last_s3;
		end
	end

	// stage 5: magnitudes
	logic [MAG_W-1:0] d_s5, mr_s5, mi_s5;
	logic             neg_r_s5, neg_i_s5, zero_s5, last_s5;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			d_s5     <= MAG_W'(d_s4);
			mr_s5    <= MAG_W'(pr_s4[SUM_W-1] ? -pr_s4 : pr_s4);
			mi_s5    <= MAG_W'(pi_s4[SUM_W-1] ? -pi_s4 : pi_s4);
			neg_r_s5 <= pr_s4[SUM_W-1];
			neg_i_s5 <= pi_s4[SUM_W-1];
			zero_s5  <= zero_s4;
			last_s5  <= last_s4;
		end
	end

	// stage 6: rounded dividend |p|*2^17 + d over 2d
	div_t div_s [QUO_W+1];

	always_ff @(posedge clk) begin
		if (en[5]) begin
			div_s[0].den   <= DIV_W'(d_s5) << 1;
			div_s[0].rem_r <= (DIV_W'(mr_s5) << FRAC_SH) + DIV_W'(d_s5);
			div_s[0].rem_i <= (DIV_W'(mi_s5) << FRAC_SH) + DIV_W'(d_s5);
			div_s[0].q_r   <= '0;
			div_s[0].q_i   <= '0;
			div_s[0].neg_r <= neg_r_s5;
			div_s[0].neg_i <= neg_i_s5;
			div_s[0].zero  <= zero_s5;
			div_s[0].last  <= last_s5;
		end
	end

	// restoring division, one quotient bit per stage, msb first
	for (genvar j = 0; j < QUO_W; j++) begin : g_div
		localparam int K = QUO_W - 1 - j;
		logic [DIV_W-1:0] sub_d;
		logic             ge_r, ge_i;
		div_t             nxt;

		always_comb begin
			sub_d     = div_s[j].den << K;
			ge_r      = div_s[j].rem_r >= sub_d;
			ge_i      = div_s[j].rem_i >= sub_d;
			nxt       = div_s[j];
			nxt.rem_r = ge_r ? div_s[j].rem_r - sub_d : div_s[j].rem_r;
			nxt.rem_i = ge_i ? div_s[j].rem_i - sub_d : div_s[j].rem_i;
			nxt.q_r   = {div_s[j].q_r[QUO_W-2:0], ge_r};
			nxt.q_i   = {div_s[j].q_i[QUO_W-2:0], ge_i};
		end

		always_ff @(posedge clk) begin
			if (en[FRONT_ST+j]) begin
				div_s[j+1] <= nxt;
			end
		end
	end

	// output stage: saturate, sign, zero divisor
	div_t             fin;
	logic [QUO_W-1:0] lim_r, lim_i;
	logic             sat_r, sat_i;
	logic [DATA_W-1:0] m_r, m_i;

	always_comb begin
		fin   = div_s[QUO_W];
		lim_r = fin.neg_r ? LIM_NEG : LIM_POS;
		lim_i = fin.neg_i ? LIM_NEG : LIM_POS;
		sat_r = fin.q_r > lim_r;
		sat_i = fin.q_i > lim_i;
		m_r   = sat_r ? lim_r[DATA_W-1:0] : fin.q_r[DATA_W-1:0];
		m_i   = sat_i ? lim_i[DATA_W-1:0] : fin.q_i[DATA_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en[NUM_ST-1]) begin
			last_out <= fin.last;
			if (fin.zero) begin
				resp_real    <= '0;
				resp_imag    <= '0;
				zero_divisor <= 1'b1;
				saturated    <= 1'b0;
			end else begin
				resp_real    <= $signed(fin.neg_r ? -m_r : m_r);
				resp_imag    <= $signed(fin.neg_i ? -m_i : m_i);
				zero_divisor <= 1'b0;
				saturated    <= sat_r || sat_i;
			end
		end
	end

	`RBU_ASSERT_IMP(a_zero_clears, clk, arst_n, resp_valid && zero_divisor,
		resp_real == '0 && resp_imag == '0 && !saturated)
	`RBU_ASSERT_IMP(a_sat_at_limit, clk, arst_n, resp_valid && saturated,
		resp_real == RESP_MAX || resp_real == RESP_MIN ||
		resp_imag == RESP_MAX || resp_imag == RESP_MIN)
	`RBU_ASSERT_IMP(a_empty_out_takes, clk, arst_n, !resp_valid, !bin_stall)
	`RBU_ASSERT_NXT(a_accept_enters, clk, arst_n, bin_valid && !bin_stall, vld_s[0])
endmodule
